[rtl/lbf_pkg.sv]
`timescale 1ns / 1ps

package lbf_pkg;

	// value and intermediate widths
	localparam int VAL_W   = 32;
	localparam int GUARD_W = 32;
	localparam int M2_W    = 2 * VAL_W - 2;
	localparam int ROOT_W  = M2_W / 2 + GUARD_W;
	localparam int A_W     = ROOT_W + 2;
	localparam int D_W     = 99;
	localparam int DMAG_W  = D_W - 2;
	localparam int DEN_W   = 128;
	localparam int Q_W     = 34;
	localparam int NUM_W   = DEN_W + Q_W;
	localparam int SQ_STEPS = ROOT_W;
	localparam int DIV_LAT  = Q_W + 1;

	// status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_PZERO = 3'd1;
	localparam logic [2:0] ST_EZERO = 3'd2;
	localparam logic [2:0] ST_SPACE = 3'd3;
	localparam logic [2:0] ST_SAT   = 3'd4;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

endpackage

[rtl/lbf_sqrt.sv]
`timescale 1ns / 1ps

module lbf_sqrt import lbf_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [M2_W-1:0]   m2,
	output logic [ROOT_W-1:0] root
);

	localparam int REM_W = ROOT_W + 2;

	logic [REM_W-1:0]  rem_q  [SQ_STEPS];
	logic [ROOT_W-1:0] root_q [SQ_STEPS];
	logic [M2_W-1:0]   m2_q   [SQ_STEPS-1];

	// one root bit per stage, radicand is m2 shifted up by two guard words
	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
		localparam int K = SQ_STEPS - 1 - i;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [M2_W-1:0]   m2_in;
		logic [1:0]        pair;
		logic [REM_W+1:0]  cur;
		logic [REM_W+1:0]  trial;

		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign m2_in   = m2;
		end else begin : g_next
			assign rem_in  = rem_q[i-1];
			assign root_in = root_q[i-1];
			assign m2_in   = m2_q[i-1];
		end

		if (K >= GUARD_W) begin : g_data
			assign pair = m2_in[2*(K-GUARD_W)+1 -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign cur   = {rem_in, pair};
		assign trial = {{(REM_W-ROOT_W){1'b0}}, root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur >= trial) begin
					rem_q[i]  <= REM_W'(cur - trial);
					root_q[i] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q[i]  <= cur[REM_W-1:0];
					root_q[i] <= {root_in[ROOT_W-2:0], 1'b0};
				end
			end
		end

		if (i < SQ_STEPS - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					m2_q[i] <= m2_in;
				end
			end
		end
	end

	assign root = root_q[SQ_STEPS-1];

endmodule

[rtl/lbf_div.sv]
`timescale 1ns / 1ps

module lbf_div import lbf_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo,
	output logic             ovf
);

	logic [DEN_W-1:0] rem_q [DIV_LAT];
	logic [DEN_W-1:0] den_q [DIV_LAT];
	logic [Q_W-1:0]   low_q [DIV_LAT];
	logic [Q_W-1:0]   quo_q [DIV_LAT];
	logic             ovf_q [DIV_LAT];

	// flag quotients that do not fit, load the top of the dividend
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_q[0] <= num[NUM_W-1:Q_W] >= den;
			rem_q[0] <= num[NUM_W-1:Q_W];
			low_q[0] <= num[Q_W-1:0];
			den_q[0] <= den;
			quo_q[0] <= '0;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar j = 1; j < DIV_LAT; j++) begin : g_step
		logic [DEN_W:0] cur;
		logic           hit;

		assign cur = {rem_q[j-1], low_q[j-1][Q_W-1]};
		assign hit = cur >= {1'b0, den_q[j-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				quo_q[j] <= {quo_q[j-1][Q_W-2:0], hit};
				ovf_q[j] <= ovf_q[j-1];
				rem_q[j] <= hit ? DEN_W'(cur - {1'b0, den_q[j-1]}) : cur[DEN_W-1:0];
				low_q[j] <= {low_q[j-1][Q_W-2:0], 1'b0};
				den_q[j] <= den_q[j-1];
			end
		end
	end

	assign quo = quo_q[DIV_LAT-1];
	assign ovf = ovf_q[DIV_LAT-1];

endmodule

[rtl/lorentz_boost_to_frame.sv]
`timescale 1ns / 1ps

// Boosts a particle four-vector into the rest frame of a reference four-vector,
// all values signed Q16.16 GeV, results rounded to nearest and saturated. The
// block is a fixed pipeline of 109 register stages that takes one item per clock
// while no result waits on a stalled output; most of its depth is the frame-mass
// square root (63 stages, one root bit each) and the four parallel rounding dividers
// (35 stages: a load stage, then one quotient bit per stage). A stall on the output
// freezes the whole pipeline, so input stall equals output valid and output stall.
// Frames with zero momentum, zero energy or no positive mass pass the particle
// through unchanged with status 1, 2 or 3; status 4 flags a clamped result.
module lorentz_boost_to_frame import lbf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [VAL_W-1:0] part_energy,
	input  logic signed [VAL_W-1:0] part_px,
	input  logic signed [VAL_W-1:0] part_py,
	input  logic signed [VAL_W-1:0] part_pz,
	input  logic signed [VAL_W-1:0] frame_energy,
	input  logic signed [VAL_W-1:0] frame_px,
	input  logic signed [VAL_W-1:0] frame_py,
	input  logic signed [VAL_W-1:0] frame_pz,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] out_energy,
	output logic signed [VAL_W-1:0] out_px,
	output logic signed [VAL_W-1:0] out_py,
	output logic signed [VAL_W-1:0] out_pz,
	output logic [2:0]              boost_status
);

	localparam int MID_STAGES = 8;
	localparam int LAT = 2 + SQ_STEPS + MID_STAGES + DIV_LAT + 1;
	localparam int X_W = Q_W + 4;
	localparam int PP_W = 2 * VAL_W + 2;
	localparam int PR_W = 2 * VAL_W;

	typedef struct packed {
		logic signed [VAL_W-1:0] pe;
		logic signed [VAL_W-1:0] px;
		logic signed [VAL_W-1:0] py;
		logic signed [VAL_W-1:0] pz;
		logic signed [VAL_W-1:0] fe;
		logic signed [VAL_W-1:0] fx;
		logic signed [VAL_W-1:0] fy;
		logic signed [VAL_W-1:0] fz;
		logic [2:0]              st;
	} vec_t;

	typedef struct packed {
		vec_t                   v;
		logic signed [PP_W-1:0] pp;
		logic signed [PR_W-1:0] ee;
	} sq_side_t;

	typedef struct packed {
		vec_t       v;
		logic [3:0] neg;
	} dv_side_t;

	typedef struct packed {
		logic                    hit;
		logic signed [VAL_W-1:0] val;
	} sat_t;

	logic en;
	logic [LAT-1:0] vld_q;

	// global advance: the whole pipe holds while a result waits
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// stage 1: squares and dot-product terms
	logic signed [PR_W-1:0] ee_s1, xx_s1, yy_s1, zz_s1, xp_s1, yp_s1, zp_s1, ep_s1;
	logic                   pz_s1, ez_s1;
	vec_t                   v_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ee_s1 <= frame_energy * frame_energy;
			xx_s1 <= frame_px * frame_px;
			yy_s1 <= frame_py * frame_py;
			zz_s1 <= frame_pz * frame_pz;
			xp_s1 <= frame_px * part_px;
			yp_s1 <= frame_py * part_py;
			zp_s1 <= frame_pz * part_pz;
			ep_s1 <= frame_energy * part_energy;
			pz_s1 <= (frame_px == '0) && (frame_py == '0) && (frame_pz == '0);
			ez_s1 <= frame_energy == '0;
			v_s1.pe <= part_energy;
			v_s1.px <= part_px;
			v_s1.py <= part_py;
			v_s1.pz <= part_pz;
			v_s1.fe <= frame_energy;
			v_s1.fx <= frame_px;
			v_s1.fy <= frame_py;
			v_s1.fz <= frame_pz;
			v_s1.st <= ST_OK;
		end
	end

	// stage 2: squared mass, dot product, special cases
	logic signed [PP_W-1:0] m2_c, pp_c;
	logic [2:0]             st_c;
	vec_t                   v_c;
	logic [M2_W-1:0]        m2_s2;
	sq_side_t               sq_s2;

	assign m2_c = PP_W'(ee_s1) - PP_W'(xx_s1) - PP_W'(yy_s1) - PP_W'(zz_s1);
	assign pp_c = PP_W'(xp_s1) + PP_W'(yp_s1) + PP_W'(zp_s1);

	always_comb begin
		priority if (pz_s1) begin
			st_c = ST_PZERO;
		end else if (ez_s1) begin
			st_c = ST_EZERO;
		end else if (m2_c <= 0) begin
			st_c = ST_SPACE;
		end else begin
			st_c = ST_OK;
		end
	end

	// attach the status to the carried vector
	always_comb begin
		v_c    = v_s1;
		v_c.st = st_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m2_s2    <= m2_c[M2_W-1:0];
			sq_s2.v  <= v_c;
			sq_s2.pp <= pp_c;
			sq_s2.ee <= ep_s1;
		end
	end

	// frame mass with guard bits
	logic [ROOT_W-1:0] mq;
	sq_side_t          sd_q [SQ_STEPS];
	sq_side_t          sd;

	lbf_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.m2   (m2_s2),
		.root (mq)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sd_q[0] <= sq_s2;
			for (int k = 1; k < SQ_STEPS; k++) begin
				sd_q[k] <= sd_q[k-1];
			end
		end
	end

	assign sd = sd_q[SQ_STEPS-1];

	// stage 3: A = |E| + m, energy numerator difference
	logic [VAL_W-1:0]         fe_mag;
	logic [A_W-1:0]           a_s3;
	logic [ROOT_W-1:0]        mq_s3;
	logic signed [PP_W:0]     dif_s3;
	logic signed [PP_W-1:0]   pp_s3;
	vec_t                     v_s3;

	assign fe_mag = sd.v.fe[VAL_W-1] ? VAL_W'(-sd.v.fe) : sd.v.fe;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3   <= {1'b0, fe_mag, {GUARD_W{1'b0}}} + A_W'(mq);
			mq_s3  <= mq;
			dif_s3 <= (PP_W+1)'(sd.ee) - (PP_W+1)'(sd.pp);
			pp_s3  <= sd.pp;
			v_s3   <= sd.v;
		end
	end

	// stage 4: partial products of e*A and m*A
	logic signed [PP_W-1:0] eal_s4, eah_s4;
	logic                   a64_s4;
	logic [63:0]            ma00_s4, ma01_s4;
	logic [62:0]            ma10_s4, ma11_s4;
	logic [ROOT_W-1:0]      mq_s4;
	logic [PP_W-1:0]        ne_mag_s4;
	logic                   ne_neg_s4;
	logic signed [PP_W-1:0] pp_s4;
	vec_t                   v_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			eal_s4    <= v_s3.pe * $signed({1'b0, a_s3[31:0]});
			eah_s4    <= v_s3.pe * $signed({1'b0, a_s3[63:32]});
			a64_s4    <= a_s3[A_W-1];
			ma00_s4   <= mq_s3[31:0] * a_s3[31:0];
			ma01_s4   <= mq_s3[31:0] * a_s3[63:32];
			ma10_s4   <= mq_s3[ROOT_W-1:32] * a_s3[31:0];
			ma11_s4   <= mq_s3[ROOT_W-1:32] * a_s3[63:32];
			mq_s4     <= mq_s3;
			ne_mag_s4 <= dif_s3[PP_W] ? PP_W'(-dif_s3) : PP_W'(dif_s3);
			ne_neg_s4 <= dif_s3[PP_W] ^ v_s3.fe[VAL_W-1];
			pp_s4     <= pp_s3;
			v_s4      <= v_s3;
		end
	end

	// stage 5: sum partial products, energy divider operands
	logic signed [D_W-1:0]  ea_s5;
	logic [DEN_W-1:0]       den_a_s5, den_b_s5, den_e_s5;
	logic [NUM_W-1:0]       num_e_s5;
	logic                   ne_neg_s5;
	logic signed [PP_W-1:0] pp_s5;
	vec_t                   v_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ea_s5 <= D_W'(eal_s4) + (D_W'(eah_s4) << 32)
				+ (a64_s4 ? (D_W'(v_s4.pe) << 64) : D_W'(0));
			den_a_s5 <= DEN_W'(ma00_s4) + (DEN_W'(ma01_s4) << 32);
			den_b_s5 <= (DEN_W'(ma10_s4) << 32) + (DEN_W'(ma11_s4) << 64)
				+ (a64_s4 ? (DEN_W'(mq_s4) << 64) : DEN_W'(0));
			num_e_s5  <= (NUM_W'(ne_mag_s4) << (GUARD_W + 1)) + NUM_W'(mq_s4);
			den_e_s5  <= DEN_W'(mq_s4) << 1;
			ne_neg_s5 <= ne_neg_s4;
			pp_s5     <= pp_s4;
			v_s5      <= v_s4;
		end
	end

	// stage 6: m*A and D = P.p - s*e*A (guard-scaled)
	logic [DEN_W-1:0]      den_s6, den_e_s6;
	logic signed [D_W-1:0] d_s6;
	logic [NUM_W-1:0]      num_e_s6;
	logic                  ne_neg_s6;
	vec_t                  v_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6 <= den_a_s5 + den_b_s5;
			if (v_s5.fe[VAL_W-1]) begin
				d_s6 <= (D_W'(pp_s5) << GUARD_W) + ea_s5;
			end else begin
				d_s6 <= (D_W'(pp_s5) << GUARD_W) - ea_s5;
			end
			num_e_s6  <= num_e_s5;
			den_e_s6  <= den_e_s5;
			ne_neg_s6 <= ne_neg_s5;
			v_s6      <= v_s5;
		end
	end

	// stage 7: magnitudes and signs of D and frame momenta
	logic signed [VAL_W-1:0] fp [3];
	logic [DMAG_W-1:0]       dmag_s7;
	logic                    dneg_s7;
	logic [VAL_W-1:0]        pmag_s7 [3];
	logic [2:0]              pneg_s7;
	logic [DEN_W-1:0]        den_s7, den_e_s7;
	logic [NUM_W-1:0]        num_e_s7;
	logic                    ne_neg_s7;
	vec_t                    v_s7;

	assign fp[0] = v_s6.fx;
	assign fp[1] = v_s6.fy;
	assign fp[2] = v_s6.fz;

	always_ff @(posedge clk) begin
		if (en) begin
			dmag_s7 <= d_s6[D_W-1] ? DMAG_W'(-d_s6) : DMAG_W'(d_s6);
			dneg_s7 <= d_s6[D_W-1];
			for (int c = 0; c < 3; c++) begin
				pmag_s7[c] <= fp[c][VAL_W-1] ? VAL_W'(-fp[c]) : fp[c];
				pneg_s7[c] <= fp[c][VAL_W-1];
			end
			den_s7    <= den_s6;
			den_e_s7  <= den_e_s6;
			num_e_s7  <= num_e_s6;
			ne_neg_s7 <= ne_neg_s6;
			v_s7      <= v_s6;
		end
	end

	// stage 8: partial products of |P_i| * |D|
	logic [63:0]      pr0_s8 [3];
	logic [63:0]      pr1_s8 [3];
	logic [63:0]      pr2_s8 [3];
	logic [VAL_W-1:0] pm_s8  [3];
	logic             b96_s8;
	logic [2:0]       nneg_s8;
	logic [DEN_W-1:0] den_s8, den_e_s8;
	logic [NUM_W-1:0] num_e_s8;
	logic             ne_neg_s8;
	vec_t             v_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				pr0_s8[c]  <= pmag_s7[c] * dmag_s7[31:0];
				pr1_s8[c]  <= pmag_s7[c] * dmag_s7[63:32];
				pr2_s8[c]  <= pmag_s7[c] * dmag_s7[95:64];
				pm_s8[c]   <= pmag_s7[c];
				nneg_s8[c] <= pneg_s7[c] ^ dneg_s7;
			end
			b96_s8    <= dmag_s7[DMAG_W-1];
			den_s8    <= den_s7;
			den_e_s8  <= den_e_s7;
			num_e_s8  <= num_e_s7;
			ne_neg_s8 <= ne_neg_s7;
			v_s8      <= v_s7;
		end
	end

	// stage 9: sum the product terms
	logic [DEN_W-1:0] prod_s9 [3];
	logic [2:0]       nneg_s9;
	logic [DEN_W-1:0] den_s9, den_e_s9;
	logic [NUM_W-1:0] num_e_s9;
	logic             ne_neg_s9;
	vec_t             v_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				prod_s9[c] <= DEN_W'(pr0_s8[c]) + (DEN_W'(pr1_s8[c]) << 32)
					+ (DEN_W'(pr2_s8[c]) << 64)
					+ (b96_s8 ? (DEN_W'(pm_s8[c]) << 96) : DEN_W'(0));
			end
			nneg_s9   <= nneg_s8;
			den_s9    <= den_s8;
			den_e_s9  <= den_e_s8;
			num_e_s9  <= num_e_s8;
			ne_neg_s9 <= ne_neg_s8;
			v_s9      <= v_s8;
		end
	end

	// stage 10: rounding dividend 2|n| + d and divisor 2d for all four lanes
	logic [NUM_W-1:0] num_s10 [4];
	logic [DEN_W-1:0] dn_s10  [4];
	dv_side_t         dv_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s10[0] <= num_e_s9;
			dn_s10[0]  <= den_e_s9;
			for (int c = 0; c < 3; c++) begin
				num_s10[c+1] <= (NUM_W'(prod_s9[c]) << (GUARD_W + 1)) + NUM_W'(den_s9);
				dn_s10[c+1]  <= den_s9 << 1;
			end
			dv_s10.v   <= v_s9;
			dv_s10.neg <= {nneg_s9, ne_neg_s9};
		end
	end

	// dividers
	logic [Q_W-1:0] quo [4];
	logic           qovf [4];
	dv_side_t       dv_q [DIV_LAT];
	dv_side_t       dv;

	for (genvar g = 0; g < 4; g++) begin : g_div
		lbf_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s10[g]),
			.den (dn_s10[g]),
			.quo (quo[g]),
			.ovf (qovf[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_q[0] <= dv_s10;
			for (int k = 1; k < DIV_LAT; k++) begin
				dv_q[k] <= dv_q[k-1];
			end
		end
	end

	assign dv = dv_q[DIV_LAT-1];

	// signed quotient plus base, clamped to the value range
	function automatic sat_t fit(input logic signed [X_W-1:0] base, input logic [Q_W-1:0] q,
		input logic neg, input logic of);
		logic signed [X_W-1:0] qs;
		logic signed [X_W-1:0] x;
		sat_t r;
		qs = neg ? -$signed({{(X_W-Q_W){1'b0}}, q}) : $signed({{(X_W-Q_W){1'b0}}, q});
		x = base + qs;
		if (of) begin
			r.hit = 1'b1;
			r.val = neg ? VAL_MIN : VAL_MAX;
		end else if (x > X_W'(VAL_MAX)) begin
			r.hit = 1'b1;
			r.val = VAL_MAX;
		end else if (x < X_W'(VAL_MIN)) begin
			r.hit = 1'b1;
			r.val = VAL_MIN;
		end else begin
			r.hit = 1'b0;
			r.val = x[VAL_W-1:0];
		end
		return r;
	endfunction

	sat_t fe_r, fx_r, fy_r, fz_r;

	assign fe_r = fit('0, quo[0], dv.neg[0], qovf[0]);
	assign fx_r = fit(X_W'(dv.v.px), quo[1], dv.neg[1], qovf[1]);
	assign fy_r = fit(X_W'(dv.v.py), quo[2], dv.neg[2], qovf[2]);
	assign fz_r = fit(X_W'(dv.v.pz), quo[3], dv.neg[3], qovf[3]);

	// output register: pass through on special frames
	always_ff @(posedge clk) begin
		if (en) begin
			if (dv.v.st != ST_OK) begin
				out_energy   <= dv.v.pe;
				out_px       <= dv.v.px;
				out_py       <= dv.v.py;
				out_pz       <= dv.v.pz;
				boost_status <= dv.v.st;
			end else begin
				out_energy   <= fe_r.val;
				out_px       <= fx_r.val;
				out_py       <= fy_r.val;
				out_pz       <= fz_r.val;
				boost_status <= (fe_r.hit || fx_r.hit || fy_r.hit || fz_r.hit) ? ST_SAT : ST_OK;
			end
		end
	end

endmodule

[rtl/lbf_checker.sv]
`timescale 1ns / 1ps

module lbf_checker import lbf_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [VAL_W-1:0] out_energy,
	input logic signed [VAL_W-1:0] out_px,
	input logic signed [VAL_W-1:0] out_py,
	input logic signed [VAL_W-1:0] out_pz,
	input logic [2:0]              boost_status
);

	// input stalls only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a waiting result");

	// a taken result frees the input
	a_stall_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |-> !in_stall)
		else $error("input stalled while output drains");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_energy) && $stable(out_px)
			&& $stable(out_py) && $stable(out_pz) && $stable(boost_status)))
		else $error("stalled result changed");

	// saturation status implies a clamped component
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && boost_status == ST_SAT) |->
			(out_energy == VAL_MAX || out_energy == VAL_MIN || out_px == VAL_MAX
			|| out_px == VAL_MIN || out_py == VAL_MAX || out_py == VAL_MIN
			|| out_pz == VAL_MAX || out_pz == VAL_MIN))
		else $error("saturation flagged without a clamped value");

	// status stays within its codes
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (boost_status <= ST_SAT))
		else $error("status code out of range");

endmodule

bind lorentz_boost_to_frame lbf_checker u_lbf_checker (.*);
